/* rtl/lfu_pkg.sv */
// Package for the LFU cache tag store: operation and status codes,
// field widths and parameter defaults. No dependencies.
`default_nettype none
package lfu_pkg;

  // Fixed field widths
  localparam int FUNC_W   = 2;
  localparam int PORTK_W  = 64;
  localparam int HASH_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int CHARGE_W = 12;
  localparam int HANDLE_W = 5;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 17;
  localparam int STAMP_W  = 32;

  // Parameter defaults
  localparam int DEF_ENTRIES   = 32;
  localparam int DEF_KEY_BITS  = 64;
  localparam int DEF_FREQ_BITS = 16;
  localparam int DEF_REF_BITS  = 8;

  localparam logic [USED_W-1:0] CAP_RESET = 17'd65535;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_ERASE   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOSLOT   = 2'd2;

  // Result kinds
  localparam logic KIND_RESULT = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

endpackage
`default_nettype wire

/* rtl/lfu_cache_tag_store.sv */
// LFU cache tag store top level: entry memory, scan sequencer and result register.
// Depends on lfu_pkg.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | func key hash value charge handle
//   out_    | output    | out_valid / out_ready| kind status entry payload evicted_key used last
//   cfg_    | input     | cfg_we               | cfg_wdata (capacity)
//
// Lookup and erase take one pass over the entry memory, plus setup and result.
// An insert over budget adds one pass per evicted entry, one more pass when no
// unpinned entry is left, and a read state and an output state per eviction notice;
// release reads the handle's entry, then checks and updates it.
// The single read port of the entry memory is why each search is a full pass.
// Reset (synchronous, rst_n low) clears the occupied bits, usage, the sequence
// counter and all control state; no clearing pass is needed.
// A stalled output holds the sequencer; the next request is taken once the
// final result of the current one is in the output register.
`default_nettype none
module lfu_cache_tag_store #(
  parameter int ENTRIES   = lfu_pkg::DEF_ENTRIES,
  parameter int KEY_BITS  = lfu_pkg::DEF_KEY_BITS,
  parameter int FREQ_BITS = lfu_pkg::DEF_FREQ_BITS,
  parameter int REF_BITS  = lfu_pkg::DEF_REF_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lfu_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [lfu_pkg::PORTK_W-1:0]   in_key,
  input  wire logic [lfu_pkg::HASH_W-1:0]    in_hash,
  input  wire logic [lfu_pkg::VALUE_W-1:0]   in_value,
  input  wire logic [lfu_pkg::CHARGE_W-1:0]  in_charge,
  input  wire logic [lfu_pkg::HANDLE_W-1:0]  in_handle,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_kind,
  output logic [lfu_pkg::STATUS_W-1:0]       out_status,
  output logic [lfu_pkg::HANDLE_W-1:0]       out_entry,
  output logic [lfu_pkg::VALUE_W-1:0]        out_payload,
  output logic [lfu_pkg::PORTK_W-1:0]        out_evicted_key,
  output logic [lfu_pkg::USED_W-1:0]         out_used,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [lfu_pkg::USED_W-1:0]    cfg_wdata
);
  import lfu_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [HASH_W-1:0]    hash;
    logic [VALUE_W-1:0]   payload;
    logic [CHARGE_W-1:0]  charge;
    logic [FREQ_BITS-1:0] freq;
    logic [STAMP_W-1:0]   stamp;
    logic [REF_BITS-1:0]  refc;
    logic                 resident;
  } entry_t;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_VSCAN  = 3'd1;
  localparam logic [2:0] S_FIND   = 3'd2;
  localparam logic [2:0] S_RELRD  = 3'd3;
  localparam logic [2:0] S_RELCHK = 3'd4;
  localparam logic [2:0] S_NRD    = 3'd5;
  localparam logic [2:0] S_NOUT   = 3'd6;
  localparam logic [2:0] S_RES    = 3'd7;

  // Entry memory and victim list
  entry_t           mem [ENTRIES];
  entry_t           mem_q_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] vic_list [ENTRIES];
  logic             vic_we;

  // Control and status registers
  logic [2:0]          state_r, state_nxt;
  logic [USED_W-1:0]   cap_r;
  logic [ENTRIES-1:0]  occ_r, occ_nxt;
  logic [USED_W-1:0]   usage_r, usage_nxt;
  logic [STAMP_W-1:0]  seq_r, seq_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]    vcnt_r, vcnt_nxt;
  logic [CNT_W-1:0]    ncnt_r, ncnt_nxt;

  // Request registers
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [CHARGE_W-1:0] charge_r, charge_nxt;
  logic [IDX_W-1:0]    handle_r, handle_nxt;

  // Scan results
  logic                bfound_r, bfound_nxt;
  logic [IDX_W-1:0]    best_r, best_nxt;
  logic [FREQ_BITS-1:0] bf_r, bf_nxt;
  logic [STAMP_W-1:0]  ba_r, ba_nxt;
  logic [CHARGE_W-1:0] bchg_r, bchg_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hidx_r, hidx_nxt;
  entry_t              hword_r, hword_nxt;
  logic                ffound_r, ffound_nxt;
  logic [IDX_W-1:0]    fidx_r, fidx_nxt;

  // Pending write and prepared result
  logic                pw_en_r, pw_en_nxt;
  logic [IDX_W-1:0]    pw_addr_r, pw_addr_nxt;
  entry_t              pw_data_r, pw_data_nxt;
  logic [STATUS_W-1:0] rs_status_r, rs_status_nxt;
  logic [IDX_W-1:0]    rs_entry_r, rs_entry_nxt;
  logic [VALUE_W-1:0]  rs_payload_r, rs_payload_nxt;

  // Output register
  logic                out_valid_r;
  logic                o_load;
  logic                o_kind;
  logic [STATUS_W-1:0] o_status;
  logic [IDX_W-1:0]    o_entry;
  logic [VALUE_W-1:0]  o_payload;
  logic [KEY_BITS-1:0] o_ekey;
  logic                o_last;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Read address selection
  always_comb begin
    unique case (state_r)
      S_RELRD, S_RELCHK: rd_addr = handle_r;
      S_NRD, S_NOUT:     rd_addr = vic_list[ncnt_r[IDX_W-1:0]];
      default:           rd_addr = scan_r[IDX_W-1:0];
    endcase
  end

  // Entry memory: one read, one write per cycle
  always_ff @(posedge clk) begin
    mem_q_r <= mem[rd_addr];
    if (state_r == S_RES && out_free && pw_en_r) begin
      mem[pw_addr_r] <= pw_data_r;
    end
  end

  // Sequencer next-state logic
  always_comb begin
    entry_t              d;
    entry_t              w;
    logic                cur_occ;
    logic                scan_done;
    logic [STAMP_W-1:0]  age;
    logic                cand;
    logic [USED_W-1:0]   u_ev;
    logic [USED_W:0]     need;
    logic                want_scan;

    state_nxt     = state_r;
    occ_nxt       = occ_r;
    usage_nxt     = usage_r;
    seq_nxt       = seq_r;
    scan_nxt      = scan_r;
    vcnt_nxt      = vcnt_r;
    ncnt_nxt      = ncnt_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    hash_nxt      = hash_r;
    value_nxt     = value_r;
    charge_nxt    = charge_r;
    handle_nxt    = handle_r;
    bfound_nxt    = bfound_r;
    best_nxt      = best_r;
    bf_nxt        = bf_r;
    ba_nxt        = ba_r;
    bchg_nxt      = bchg_r;
    hit_nxt       = hit_r;
    hidx_nxt      = hidx_r;
    hword_nxt     = hword_r;
    ffound_nxt    = ffound_r;
    fidx_nxt      = fidx_r;
    pw_en_nxt     = pw_en_r;
    pw_addr_nxt   = pw_addr_r;
    pw_data_nxt   = pw_data_r;
    rs_status_nxt = rs_status_r;
    rs_entry_nxt  = rs_entry_r;
    rs_payload_nxt = rs_payload_r;
    vic_we        = 1'b0;
    o_load        = 1'b0;
    o_kind        = KIND_RESULT;
    o_status      = ST_OK;
    o_entry       = '0;
    o_payload     = '0;
    o_ekey        = '0;
    o_last        = 1'b1;

    d         = mem_q_r;
    w         = mem_q_r;
    cur_occ   = occ_r[rd_idx_r];
    scan_done = rd_vld_r && (rd_idx_r == IDX_W'(ENTRIES - 1));
    age       = seq_r - d.stamp;
    u_ev      = usage_r;
    need      = '0;
    want_scan = 1'b0;
    cand      = 1'b0;

    // Reads are issued while a scan has addresses left
    rd_vld_nxt = ((state_r == S_VSCAN) || (state_r == S_FIND)) &&
                 (scan_r < CNT_W'(ENTRIES));
    rd_idx_nxt = scan_r[IDX_W-1:0];
    if (rd_vld_nxt) begin
      scan_nxt = scan_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          key_nxt    = in_key[KEY_BITS-1:0];
          hash_nxt   = in_hash;
          value_nxt  = in_value;
          charge_nxt = in_charge;
          handle_nxt = IDX_W'(in_handle);
          vcnt_nxt   = '0;
          pw_en_nxt  = 1'b0;
          scan_nxt   = '0;
          bfound_nxt = 1'b0;
          hit_nxt    = 1'b0;
          ffound_nxt = 1'b0;
          need = {1'b0, usage_r} + (USED_W + 1)'(in_charge);
          priority if (in_func == FUNC_RELEASE) begin
            if ((32'(in_handle) < 32'(ENTRIES)) && occ_r[IDX_W'(in_handle)]) begin
              state_nxt = S_RELRD;
            end else begin
              rs_status_nxt  = ST_NOTFOUND;
              rs_entry_nxt   = '0;
              rs_payload_nxt = '0;
              state_nxt      = S_RES;
            end
          end else if (in_func == FUNC_INSERT && need > {1'b0, cap_r}) begin
            state_nxt = S_VSCAN;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end

      // Victim search: lowest frequency, then oldest, then lowest index
      S_VSCAN: begin
        cand = rd_vld_r && cur_occ && d.resident && (d.refc == '0);
        if (cand && (!bfound_r || d.freq < bf_r || (d.freq == bf_r && age > ba_r))) begin
          bfound_nxt = 1'b1;
          best_nxt   = rd_idx_r;
          bf_nxt     = d.freq;
          ba_nxt     = age;
          bchg_nxt   = d.charge;
        end
        if (scan_done) begin
          scan_nxt   = '0;
          if (bfound_nxt) begin
            vic_we = 1'b1;
            occ_nxt[best_nxt] = 1'b0;
            u_ev = (usage_r >= USED_W'(bchg_nxt)) ? usage_r - USED_W'(bchg_nxt) : '0;
            usage_nxt = u_ev;
            vcnt_nxt  = vcnt_r + 1'b1;
            need = {1'b0, u_ev} + (USED_W + 1)'(charge_r);
            want_scan = need > {1'b0, cap_r};
          end
          bfound_nxt = 1'b0;
          state_nxt = want_scan ? S_VSCAN : S_FIND;
        end
      end

      // Key match and first free slot
      S_FIND: begin
        if (rd_vld_r && cur_occ && d.resident && d.key == key_r && d.hash == hash_r &&
            !hit_r) begin
          hit_nxt   = 1'b1;
          hidx_nxt  = rd_idx_r;
          hword_nxt = d;
        end
        if (rd_vld_r && !cur_occ && !ffound_r) begin
          ffound_nxt = 1'b1;
          fidx_nxt   = rd_idx_r;
        end
        if (scan_done) begin
          w              = hword_nxt;
          rs_status_nxt  = ST_OK;
          rs_entry_nxt   = hidx_nxt;
          rs_payload_nxt = '0;
          pw_addr_nxt    = hidx_nxt;
          if (hit_nxt && func_r != FUNC_ERASE) begin
            // Hit: raise frequency, make newest, take a reference
            if (!(&w.freq)) w.freq = w.freq + 1'b1;
            if (!(&w.refc)) w.refc = w.refc + 1'b1;
            w.stamp        = seq_r;
            seq_nxt        = seq_r + 1'b1;
            pw_en_nxt      = 1'b1;
            rs_payload_nxt = w.payload;
          end else if (hit_nxt) begin
            // Erase hit
            w.resident = 1'b0;
            pw_en_nxt  = 1'b1;
            if (w.refc == '0) begin
              occ_nxt[hidx_nxt] = 1'b0;
              usage_nxt = (usage_r >= USED_W'(w.charge)) ?
                          usage_r - USED_W'(w.charge) : '0;
            end
          end else if (func_r == FUNC_INSERT) begin
            if (ffound_nxt) begin
              w.key      = key_r;
              w.hash     = hash_r;
              w.payload  = value_r;
              w.charge   = charge_r;
              w.freq     = FREQ_BITS'(1);
              w.stamp    = seq_r;
              w.refc     = REF_BITS'(1);
              w.resident = 1'b1;
              seq_nxt    = seq_r + 1'b1;
              occ_nxt[fidx_nxt] = 1'b1;
              usage_nxt  = usage_r + USED_W'(charge_r);
              pw_en_nxt  = 1'b1;
              pw_addr_nxt    = fidx_nxt;
              rs_entry_nxt   = fidx_nxt;
              rs_payload_nxt = value_r;
            end else begin
              rs_status_nxt = ST_NOSLOT;
              rs_entry_nxt  = '0;
            end
          end else begin
            rs_status_nxt = ST_NOTFOUND;
            rs_entry_nxt  = '0;
          end
          pw_data_nxt = w;
          ncnt_nxt    = '0;
          state_nxt   = (vcnt_r != '0) ? S_NRD : S_RES;
        end
      end

      S_RELRD: begin
        state_nxt = S_RELCHK;
      end

      // Release: drop a reference, free a non-resident entry at zero
      S_RELCHK: begin
        rs_payload_nxt = '0;
        if (d.refc == '0) begin
          rs_status_nxt = ST_NOTFOUND;
          rs_entry_nxt  = '0;
        end else begin
          w.refc = d.refc - 1'b1;
          if (w.refc == '0 && !d.resident) begin
            occ_nxt[handle_r] = 1'b0;
            usage_nxt = (usage_r >= USED_W'(d.charge)) ?
                        usage_r - USED_W'(d.charge) : '0;
          end
          pw_en_nxt     = 1'b1;
          pw_addr_nxt   = handle_r;
          pw_data_nxt   = w;
          rs_status_nxt = ST_OK;
          rs_entry_nxt  = handle_r;
        end
        state_nxt = S_RES;
      end

      S_NRD: begin
        state_nxt = S_NOUT;
      end

      // Eviction notice from the victim's stored key
      S_NOUT: begin
        if (out_free) begin
          o_load   = 1'b1;
          o_kind   = KIND_NOTICE;
          o_status = ST_OK;
          o_entry  = vic_list[ncnt_r[IDX_W-1:0]];
          o_ekey   = d.key;
          o_last   = 1'b0;
          ncnt_nxt = ncnt_r + 1'b1;
          state_nxt = (ncnt_nxt == vcnt_r) ? S_RES : S_NRD;
        end
      end

      S_RES: begin
        if (out_free) begin
          o_load    = 1'b1;
          o_kind    = KIND_RESULT;
          o_status  = rs_status_r;
          o_entry   = rs_entry_r;
          o_payload = rs_payload_r;
          o_last    = 1'b1;
          pw_en_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Victim list
  always_ff @(posedge clk) begin
    if (vic_we) begin
      vic_list[vcnt_r[IDX_W-1:0]] <= best_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      usage_r     <= '0;
      seq_r       <= '0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      vcnt_r      <= '0;
      ncnt_r      <= '0;
      bfound_r    <= 1'b0;
      hit_r       <= 1'b0;
      ffound_r    <= 1'b0;
      pw_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      occ_r    <= occ_nxt;
      usage_r  <= usage_nxt;
      seq_r    <= seq_nxt;
      scan_r   <= scan_nxt;
      rd_vld_r <= rd_vld_nxt;
      vcnt_r   <= vcnt_nxt;
      ncnt_r   <= ncnt_nxt;
      bfound_r <= bfound_nxt;
      hit_r    <= hit_nxt;
      ffound_r <= ffound_nxt;
      pw_en_r  <= pw_en_nxt;
      if (o_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    hash_r       <= hash_nxt;
    value_r      <= value_nxt;
    charge_r     <= charge_nxt;
    handle_r     <= handle_nxt;
    best_r       <= best_nxt;
    bf_r         <= bf_nxt;
    ba_r         <= ba_nxt;
    bchg_r       <= bchg_nxt;
    hidx_r       <= hidx_nxt;
    hword_r      <= hword_nxt;
    fidx_r       <= fidx_nxt;
    pw_addr_r    <= pw_addr_nxt;
    pw_data_r    <= pw_data_nxt;
    rs_status_r  <= rs_status_nxt;
    rs_entry_r   <= rs_entry_nxt;
    rs_payload_r <= rs_payload_nxt;
    if (o_load) begin
      out_kind        <= o_kind;
      out_status      <= o_status;
      out_entry       <= HANDLE_W'(o_entry);
      out_payload     <= o_payload;
      out_evicted_key <= PORTK_W'(o_ekey);
      out_used        <= usage_r;
      out_last        <= o_last;
    end
  end

endmodule
`default_nettype wire

/* verif/lfu_cache_tag_store_test.sv */
// Self-checking testbench for the LFU cache tag store: directed and random
// lookup, insert, release and erase requests, checked against a predictor.
// Depends on lfu_pkg and the lfu_cache_tag_store RTL.
`default_nettype none

class lfu_result_board;
  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [4:0]  entry;
    logic [31:0] payload;
    logic [63:0] evicted_key;
    logic [16:0] used;
    logic        last;
  } lfu_result_t;

  // Predictor state.
  bit [16:0] capacity;
  bit        occupied [32];
  bit [63:0] slot_key [32];
  bit [31:0] slot_hash [32];
  bit [31:0] slot_payload [32];
  bit [11:0] slot_charge [32];
  bit [15:0] slot_freq [32];
  bit [31:0] slot_stamp [32];
  bit [7:0]  slot_refs [32];
  bit        slot_resident [32];
  bit [16:0] usage;
  bit [31:0] seq_count;

  lfu_result_t pending_results [$];
  int mismatches;
  int results_seen;
  int notices_seen;

  function new();
    capacity = lfu_pkg::CAP_RESET;
    usage = '0;
    seq_count = '0;
    mismatches = 0;
    results_seen = 0;
    notices_seen = 0;
    foreach (occupied[i]) begin
      occupied[i] = 1'b0;
      slot_resident[i] = 1'b0;
    end
  endfunction

  function int find_key(bit [63:0] k, bit [31:0] h);
    for (int i = 0; i < 32; i++)
      if (occupied[i] && slot_resident[i] && slot_key[i] == k && slot_hash[i] == h)
        return i;
    return -1;
  endfunction

  function int lfu_victim();
    int best;
    bit [15:0] bf;
    bit [31:0] ba;
    bit [31:0] age;
    best = -1;
    bf = '0;
    ba = '0;
    for (int i = 0; i < 32; i++) begin
      if (!occupied[i] || !slot_resident[i] || slot_refs[i] != 0) continue;
      age = seq_count - slot_stamp[i];
      if (best < 0 || slot_freq[i] < bf || (slot_freq[i] == bf && age > ba)) begin
        best = i;
        bf = slot_freq[i];
        ba = age;
      end
    end
    return best;
  endfunction

  function void hit(int i);
    if (slot_freq[i] != 16'hFFFF) slot_freq[i]++;
    slot_stamp[i] = seq_count;
    seq_count++;
    if (slot_refs[i] != 8'hFF) slot_refs[i]++;
  endfunction

  function void free_slot(int i);
    usage = (usage >= slot_charge[i]) ? usage - slot_charge[i] : '0;
    occupied[i] = 1'b0;
    slot_resident[i] = 1'b0;
  endfunction

  function lfu_result_t mk(logic kind, logic [1:0] st, int e, logic [31:0] p,
                           logic [63:0] ek, logic last);
    lfu_result_t r;
    r.kind = kind;
    r.status = st;
    r.entry = e[4:0];
    r.payload = p;
    r.evicted_key = ek;
    r.used = '0;
    r.last = last;
    return r;
  endfunction

  // Work out the results of one accepted request and queue them.
  function void note_request(logic [1:0] func, logic [63:0] k, logic [31:0] h,
                             logic [31:0] val, logic [11:0] chg, logic [4:0] hd);
    lfu_result_t batch [$];
    int i;
    int v;
    int j;
    case (func)
      lfu_pkg::FUNC_LOOKUP: begin
        i = find_key(k, h);
        if (i < 0)
          batch = {batch, mk(lfu_pkg::KIND_RESULT, lfu_pkg::ST_NOTFOUND, 0, 0, 0, 1)};
        else begin
          hit(i);
          batch = {batch, mk(lfu_pkg::KIND_RESULT, lfu_pkg::ST_OK, i, slot_payload[i],
                             0, 1)};
        end
      end
      lfu_pkg::FUNC_INSERT: begin
        while (32'(usage) + 32'(chg) > 32'(capacity)) begin
          v = lfu_victim();
          if (v < 0) break;
          batch = {batch, mk(lfu_pkg::KIND_NOTICE, lfu_pkg::ST_OK, v, 0, slot_key[v], 0)};
          free_slot(v);
        end
        i = find_key(k, h);
        if (i >= 0) begin
          hit(i);
          batch = {batch, mk(lfu_pkg::KIND_RESULT, lfu_pkg::ST_OK, i, slot_payload[i],
                             0, 1)};
        end else begin
          for (j = 0; j < 32; j++) if (!occupied[j]) break;
          if (j >= 32)
            batch = {batch, mk(lfu_pkg::KIND_RESULT, lfu_pkg::ST_NOSLOT, 0, 0, 0, 1)};
          else begin
            occupied[j] = 1'b1;
            slot_resident[j] = 1'b1;
            slot_key[j] = k;
            slot_hash[j] = h;
            slot_payload[j] = val;
            slot_charge[j] = chg;
            slot_freq[j] = 16'd1;
            slot_stamp[j] = seq_count;
            seq_count++;
            slot_refs[j] = 8'd1;
            usage = usage + chg;
            batch = {batch, mk(lfu_pkg::KIND_RESULT, lfu_pkg::ST_OK, j, val, 0, 1)};
          end
        end
      end
      lfu_pkg::FUNC_RELEASE: begin
        if (!occupied[hd] || slot_refs[hd] == 0)
          batch = {batch, mk(lfu_pkg::KIND_RESULT, lfu_pkg::ST_NOTFOUND, 0, 0, 0, 1)};
        else begin
          slot_refs[hd]--;
          if (slot_refs[hd] == 0 && !slot_resident[hd]) free_slot(hd);
          batch = {batch, mk(lfu_pkg::KIND_RESULT, lfu_pkg::ST_OK, hd, 0, 0, 1)};
        end
      end
      default: begin
        i = find_key(k, h);
        if (i < 0)
          batch = {batch, mk(lfu_pkg::KIND_RESULT, lfu_pkg::ST_NOTFOUND, 0, 0, 0, 1)};
        else begin
          slot_resident[i] = 1'b0;
          if (slot_refs[i] == 0) free_slot(i);
          batch = {batch, mk(lfu_pkg::KIND_RESULT, lfu_pkg::ST_OK, i, 0, 0, 1)};
        end
      end
    endcase
    // Every result of a request carries the usage after the whole request.
    foreach (batch[n]) begin
      batch[n].used = usage;
      pending_results = {pending_results, batch[n]};
    end
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(lfu_result_t got);
    lfu_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    if (got.kind == lfu_pkg::KIND_NOTICE) notices_seen++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
    end
  endfunction
endclass

module lfu_cache_tag_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_func;
  logic [63:0] in_key;
  logic [31:0] in_hash;
  logic [31:0] in_value;
  logic [11:0] in_charge;
  logic [4:0] in_handle;
  logic out_valid;
  logic out_ready;
  logic out_kind;
  logic [1:0] out_status;
  logic [4:0] out_entry;
  logic [31:0] out_payload;
  logic [63:0] out_evicted_key;
  logic [16:0] out_used;
  logic out_last;
  logic cfg_we;
  logic [16:0] cfg_wdata;

  lfu_result_board board;
  bit stim_done;
  int requests_sent;

  // Small pool of keys so that hits, duplicates and erases happen often.
  logic [63:0] key_pool [8];
  logic [31:0] hash_pool [8];

  lfu_cache_tag_store dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func), .in_key(in_key),
    .in_hash(in_hash), .in_value(in_value), .in_charge(in_charge),
    .in_handle(in_handle),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_status(out_status), .out_entry(out_entry), .out_payload(out_payload),
    .out_evicted_key(out_evicted_key), .out_used(out_used), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Send one request and wait until it is accepted.
  task automatic send_request(logic [1:0] f, logic [63:0] k, logic [31:0] h,
                              logic [31:0] v, logic [11:0] c, logic [4:0] hd);
    in_valid = 1'b1;
    in_func = f;
    in_key = k;
    in_hash = h;
    in_value = v;
    in_charge = c;
    in_handle = hd;
    do @(posedge clk); while (!in_ready);
    board.note_request(f, k, h, v, c, hd);
    requests_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for all results, then the block's pass time, before a config write.
  task automatic drain_and_settle();
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_capacity(logic [16:0] cap);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.capacity = cap;
  endtask

  // Random request biased towards the key pool.
  task automatic send_random();
    int p;
    logic [1:0] f;
    logic [63:0] k;
    logic [31:0] h;
    logic [11:0] c;
    p = $urandom_range(0, 7);
    f = 2'($urandom_range(0, 3));
    k = key_pool[p];
    h = hash_pool[p];
    if ($urandom_range(0, 9) == 0) begin
      k = {$urandom, $urandom};
      h = $urandom;
    end
    c = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
    send_request(f, k, h, $urandom, c, 5'($urandom));
  endtask

  // Receiver: stall pattern alternating ready runs and stalls.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result('{out_kind, out_status, out_entry, out_payload,
                           out_evicted_key, out_used, out_last});
  end

  // Stimulus.
  initial begin
    board = new();
    stim_done = 1'b0;
    requests_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = lfu_pkg::FUNC_LOOKUP;
    in_key = '0;
    in_hash = '0;
    in_value = '0;
    in_charge = '0;
    in_handle = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      hash_pool[i] = $urandom;
    end
    key_pool[0] = '1;
    hash_pool[0] = '1;
    key_pool[1] = '0;
    hash_pool[1] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: misses, insert, hit, duplicate insert, releases, erase.
    send_request(lfu_pkg::FUNC_LOOKUP, '1, '1, 0, 0, 0);
    send_request(lfu_pkg::FUNC_INSERT, '1, '1, '1, 12'hFFF, 5'd31);
    send_request(lfu_pkg::FUNC_INSERT, '0, '0, '0, 12'd0, 5'd0);
    send_request(lfu_pkg::FUNC_LOOKUP, '1, '1, 0, 0, 0);
    send_request(lfu_pkg::FUNC_INSERT, '1, '1, 32'h1234, 12'd5, 0);
    send_request(lfu_pkg::FUNC_RELEASE, 0, 0, 0, 0, 5'd0);
    send_request(lfu_pkg::FUNC_RELEASE, 0, 0, 0, 0, 5'd0);
    send_request(lfu_pkg::FUNC_RELEASE, 0, 0, 0, 0, 5'd31);
    send_request(lfu_pkg::FUNC_ERASE, '1, '1, 0, 0, 0);
    send_request(lfu_pkg::FUNC_LOOKUP, '1, '1, 0, 0, 0);
    send_request(lfu_pkg::FUNC_RELEASE, 0, 0, 0, 0, 5'd1);
    send_request(lfu_pkg::FUNC_ERASE, '0, '0, 0, 0, 0);
    send_request(lfu_pkg::FUNC_ERASE, '0, '0, 0, 0, 0);
    // Fill every slot, then two more to hit the no-free-slot case.
    for (int i = 0; i < 33; i++)
      send_request(lfu_pkg::FUNC_INSERT, 64'(i + 100), 32'(i), 32'(i), 12'd1, 0);
    // Unpin a few and force evictions with capacity zero.
    for (int i = 0; i < 4; i++) send_request(lfu_pkg::FUNC_RELEASE, 0, 0, 0, 0, 5'(i));
    write_capacity(17'd0);
    send_request(lfu_pkg::FUNC_INSERT, 64'd7, 32'd7, 32'd7, 12'd1, 0);
    // Release the rest so random traffic has room.
    for (int i = 0; i < 32; i++) send_request(lfu_pkg::FUNC_RELEASE, 0, 0, 0, 0, 5'(i));
    write_capacity(17'h1FFFF);
    for (int i = 0; i < 32; i++)
      send_request(lfu_pkg::FUNC_ERASE, 64'(i + 100), 32'(i), 0, 0, 0);

    // Random phases at several capacities, sent in bursts with gaps.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_capacity(17'd800);
        1: write_capacity(17'($urandom_range(0, 131071)));
        2: write_capacity(17'd2000);
        default: write_capacity(lfu_pkg::CAP_RESET);
      endcase
      for (int n = 0; n < 22; ) begin
        int burst;
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && n < 22; b++, n++) send_random();
        if (phase == 1 && n >= 11 && n - burst < 11)
          while (board.pending_results.size() != 0) @(negedge clk);
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end

    drain_and_settle();
    stim_done = 1'b1;
  end

  // Final report.
  initial begin
    wait (stim_done);
    $display("%0d requests sent, %0d results checked, %0d eviction notices seen",
             requests_sent, board.results_seen, board.notices_seen);
    if (board.mismatches == 0 && board.pending_results.size() == 0)
      $display("[lfu_cache_tag_store] OK");
    else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending_results.size());
      $display("[lfu_cache_tag_store] ERROR");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #4ms;
    $display("timeout with %0d results outstanding", board.pending_results.size());
    $display("[lfu_cache_tag_store] ERROR");
    $finish;
  end
endmodule
